// ===== hw/rtl/bale_pkg.sv =====
// Shared types and constants for the bounded array list engine.
`timescale 1ns / 1ps
`default_nettype none
package bale_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int COORD_W = 64;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_ENABLED = 2'd1;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 7'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_LIST = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // What one cell does at the next edge
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_LOAD       = 2'd1,
        OP_FROM_LEFT  = 2'd2,
        OP_FROM_RIGHT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [COORD_W-1:0]  read_x;
        logic [COORD_W-1:0]  read_y;
        logic [COORD_W-1:0]  read_z;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/bale_cell.sv =====
// One list slot: holds an entry and takes a new one from input or a neighbor.
`timescale 1ns / 1ps
`default_nettype none
module bale_cell (
    input  wire logic              i_clk,
    input  wire bale_pkg::t_cell_op i_op,
    input  wire bale_pkg::t_entry  i_load,
    input  wire bale_pkg::t_entry  i_left,
    input  wire bale_pkg::t_entry  i_right,
    output bale_pkg::t_entry       o_entry
);
    import bale_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        unique case (i_op)
            OP_LOAD:       n_entry = i_load;
            OP_FROM_LEFT:  n_entry = i_left;
            OP_FROM_RIGHT: n_entry = i_right;
            default:       n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_array_list_engine_top.sv =====
// Top level of the bounded array list engine: control, cell row and result register.
// A result is registered in o_out_data in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; insert and remove shift the
// cells from the given position up in that same cycle, reads select one cell directly.
// Input stalls only while a result is held and the output side stalls.
// Reset clears count, enable and result valid, sets max entries to 1; entries are kept.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_list_engine_top #(
    parameter int DEPTH = bale_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bale_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bale_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire bale_pkg::t_request              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output bale_pkg::t_result                    o_out_data
);
    import bale_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH) + 1;
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    logic [COUNT_W-1:0] r_max_entries, n_max_entries;
    logic               r_list_enabled, n_list_enabled;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               accept;
    logic               do_op;
    t_status            status;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    max_ext;
    logic [CMPW-1:0]    limit;
    logic [AW-1:0]      rd_idx;
    t_entry             load_entry;
    t_entry             rd_entry;
    t_entry             w_cells [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign cnt_ext = CMPW'(r_count);
    assign pos_ext = CMPW'(i_in_data.position);
    assign max_ext = CMPW'(r_max_entries);
    assign limit   = (max_ext > DEPTH_C) ? DEPTH_C : max_ext;
    assign rd_idx  = AW'(pos_ext);
    assign rd_entry = w_cells[rd_idx];

    assign load_entry.x = i_in_data.coord_x;
    assign load_entry.y = i_in_data.coord_y;
    assign load_entry.z = i_in_data.coord_z;

    // Checks in order: disabled, unknown kind, full, index range
    always_comb begin
        priority if (!r_list_enabled) begin
            status = ST_NO_LIST;
        end else if (i_in_data.kind > KIND_WRITE) begin
            status = ST_OK;
        end else if ((i_in_data.kind == KIND_APPEND || i_in_data.kind == KIND_INSERT)
                     && cnt_ext >= limit) begin
            status = ST_FULL;
        end else if (i_in_data.kind != KIND_APPEND && pos_ext >= cnt_ext) begin
            status = ST_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    assign do_op = accept && status == ST_OK && i_in_data.kind <= KIND_WRITE;

    // Cell row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(gi);
        t_cell_op op;
        t_entry   left_entry;
        t_entry   right_entry;

        if (gi == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_left
            assign left_entry = w_cells[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_right
            assign right_entry = w_cells[gi+1];
        end

        always_comb begin
            op = OP_HOLD;
            if (do_op) begin
                unique case (i_in_data.kind)
                    KIND_APPEND: begin
                        if (IDX == cnt_ext) op = OP_LOAD;
                    end
                    KIND_INSERT: begin
                        if (IDX == pos_ext) op = OP_LOAD;
                        else if (IDX > pos_ext && IDX <= cnt_ext) op = OP_FROM_LEFT;
                    end
                    KIND_REMOVE: begin
                        if (IDX >= pos_ext && IDX + CMPW'(1) < cnt_ext) op = OP_FROM_RIGHT;
                    end
                    KIND_WRITE: begin
                        if (IDX == pos_ext) op = OP_LOAD;
                    end
                    default: op = OP_HOLD;
                endcase
            end
        end

        bale_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (op),
            .i_load  (load_entry),
            .i_left  (left_entry),
            .i_right (right_entry),
            .o_entry (w_cells[gi])
        );
    end

    // Control registers, count and result
    always_comb begin
        n_max_entries  = r_max_entries;
        n_list_enabled = r_list_enabled;
        n_count        = r_count;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAX_ENTRIES) begin
                if (!r_list_enabled) n_max_entries = i_cfg_data;
            end else if (i_cfg_idx == REG_LIST_ENABLED) begin
                n_list_enabled = i_cfg_data[0];
                if (i_cfg_data[0] && !r_list_enabled) n_count = '0;
            end
        end

        if (do_op) begin
            if (i_in_data.kind == KIND_APPEND || i_in_data.kind == KIND_INSERT) begin
                n_count = r_count + COUNT_W'(1);
            end else if (i_in_data.kind == KIND_REMOVE) begin
                n_count = r_count - COUNT_W'(1);
            end
        end

        if (accept) begin
            n_out_valid       = 1'b1;
            n_out.status      = status;
            n_out.entry_count = (do_op) ? n_count : r_count;
            if (do_op && i_in_data.kind == KIND_READ) begin
                n_out.read_x = rd_entry.x;
                n_out.read_y = rd_entry.y;
                n_out.read_z = rd_entry.z;
            end else begin
                n_out.read_x = '0;
                n_out.read_y = '0;
                n_out.read_z = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries  <= MAX_ENTRIES_RESET;
            r_list_enabled <= 1'b0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_max_entries  <= n_max_entries;
            r_list_enabled <= n_list_enabled;
            r_count        <= n_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/bale_checker.sv =====
// Port-level checks for the bounded array list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bale_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire bale_pkg::t_result o_out_data
);
    import bale_pkg::*;

    // Result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // Failed requests return zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.read_x == '0 && o_out_data.read_y == '0 &&
            o_out_data.read_z == '0)
        else $error("failed request carries read data");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted item yields a result at the next edge
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

bind bounded_array_list_engine_top bale_checker u_bale_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== tb/sv/bounded_array_list_engine_top_test.sv =====
// Self-checking testbench for the bounded array list engine, with random idling on both sides.
`timescale 1ns / 1ps
module bounded_array_list_engine_top_test;
    import bale_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int ITEM_GOAL = 1350;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_request i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_result o_out_data;

    bounded_array_list_engine_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the list: entries, count and the two registers
    t_entry shadow [DEPTH];
    int held = 0;
    int cap_reg = MAX_ENTRIES_RESET;
    bit list_on = 1'b0;

    t_request req_q[$];
    t_result owed_results[$];
    int sent = 0;
    int fails = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;

    function automatic int cap_limit();
        return (cap_reg > DEPTH) ? DEPTH : cap_reg;
    endfunction

    function automatic t_result apply_request(t_request r);
        t_result res;
        res = '0;
        if (!list_on) begin
            res.status = ST_NO_LIST;
        end else if (r.kind > KIND_WRITE) begin
            res.status = ST_OK;
        end else if ((r.kind == KIND_APPEND || r.kind == KIND_INSERT) && held >= cap_limit()) begin
            res.status = ST_FULL;
        end else if (r.kind != KIND_APPEND && r.position >= held) begin
            res.status = ST_RANGE;
        end else begin
            case (r.kind)
                KIND_APPEND: begin
                    shadow[held] = '{r.coord_x, r.coord_y, r.coord_z};
                    held++;
                end
                KIND_INSERT: begin
                    for (int i = held; i > r.position; i--)
                        if (i < DEPTH) shadow[i] = shadow[i-1];
                    shadow[r.position] = '{r.coord_x, r.coord_y, r.coord_z};
                    held++;
                end
                KIND_REMOVE: begin
                    for (int i = r.position; i + 1 < held; i++)
                        shadow[i] = shadow[i+1];
                    held--;
                end
                KIND_READ: begin
                    res.read_x = shadow[r.position].x;
                    res.read_y = shadow[r.position].y;
                    res.read_z = shadow[r.position].z;
                end
                default: begin
                    shadow[r.position] = '{r.coord_x, r.coord_y, r.coord_z};
                end
            endcase
        end
        res.entry_count = held[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fails < 40)
            $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        fails++;
    endtask

    // Driver: hold a stalled item, else insert a gap burst or present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid)
                owed_results.insert(owed_results.size(), apply_request(i_in_data));
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                i_in_data <= req_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each taken result against the oldest owed one
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unowed result count", o_out_data.entry_count, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.read_x !== want.read_x)
                        report_mismatch("read_x", o_out_data.read_x, want.read_x);
                    if (o_out_data.read_y !== want.read_y)
                        report_mismatch("read_y", o_out_data.read_y, want.read_y);
                    if (o_out_data.read_z !== want.read_z)
                        report_mismatch("read_z", o_out_data.read_z, want.read_z);
                    if (o_out_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", o_out_data.entry_count,
                                        want.entry_count);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 15);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_request mk(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                    logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                    logic [COORD_W-1:0] z);
        t_request r;
        r.kind = kind;
        r.position = pos;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    // Bias kinds by fill level and keep most positions inside the list
    function automatic t_request rand_request();
        int r;
        int fill;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0] pos;
        fill = (held * 2 < cap_limit()) ? 50 : 25;
        r = $urandom_range(0, 99);
        if (r < fill)
            kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
        else if (r < 95)
            kind = KIND_W'($urandom_range(KIND_REMOVE, KIND_WRITE));
        else
            kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        r = $urandom_range(0, 19);
        if (r == 0)
            pos = POS_W'($urandom_range(0, DEPTH - 1));
        else if (r == 1 || held == 0)
            pos = POS_W'((held > DEPTH - 1) ? DEPTH - 1 : held);
        else
            pos = POS_W'($urandom_range(0, held - 1));
        return mk(kind, pos, rand_word(), rand_word(), rand_word());
    endfunction

    function automatic logic [CFG_W-1:0] pick_capacity();
        case ($urandom_range(0, 8))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'(DEPTH);
            4: return '1;
            5: return CFG_W'($urandom_range(DEPTH + 1, 126));
            6: return CFG_W'($urandom_range(13, DEPTH - 1));
            default: return CFG_W'($urandom_range(3, 12));
        endcase
    endfunction

    // Keep the queue short so positions follow the live count
    task automatic queue_item(t_request r);
        while (req_q.size() >= 2) @(negedge i_clk);
        req_q.insert(req_q.size(), r);
        if (list_on) sent++;
    endtask

    task automatic settle();
        while (req_q.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MAX_ENTRIES) begin
            if (!list_on) cap_reg = data;
        end else if (idx == REG_LIST_ENABLED) begin
            if (data[0] && !list_on) held = 0;
            list_on = data[0];
        end
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int mode;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rejected before the list exists
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        queue_item(mk(KIND_APPEND, 0, '1, '1, '1));
        settle();
        write_reg(REG_MAX_ENTRIES, 7'd2);
        write_reg(REG_LIST_ENABLED, 7'd1);

        // Empty list, fill to capacity, overflow, edit and shift
        queue_item(mk(KIND_INSERT, 0, 1, 2, 3));
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        queue_item(mk(KIND_REMOVE, 0, 0, 0, 0));
        queue_item(mk(KIND_WRITE, 0, 4, 5, 6));
        queue_item(mk(KIND_APPEND, '1, '1, '1, '1));
        queue_item(mk(KIND_APPEND, 0, '0, '0, '0));
        queue_item(mk(KIND_APPEND, 0, 7, 8, 9));
        queue_item(mk(KIND_INSERT, 0, 7, 8, 9));
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        queue_item(mk(KIND_READ, 1, 0, 0, 0));
        queue_item(mk(KIND_READ, 2, 0, 0, 0));
        queue_item(mk(KIND_WRITE, 1, 64'hA5A5_5A5A_F00D_0001, 64'h8000_0000_0000_0000,
                      64'h0123_4567_89AB_CDEF));
        queue_item(mk(KIND_READ, 1, 0, 0, 0));
        queue_item(mk(KIND_REMOVE, 0, 0, 0, 0));
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        queue_item(mk(KIND_INSERT, 0, 11, 12, 13));
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        queue_item(mk(KIND_READ, 1, 0, 0, 0));
        queue_item(mk(KIND_REMOVE, '1, 0, 0, 0));
        queue_item(mk(KIND_UNUSED_LO, 0, '1, '1, '1));
        queue_item(mk(KIND_UNUSED_MID, '1, 0, 0, 0));
        queue_item(mk(KIND_UNUSED_HI, 1, 0, 0, 0));
        settle();

        // Capacity write while enabled is dropped; spare indexes do nothing
        write_reg(REG_MAX_ENTRIES, 7'd5);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        queue_item(mk(KIND_APPEND, 0, 1, 1, 1));
        settle();
        write_reg(REG_LIST_ENABLED, 7'd0);
        queue_item(mk(KIND_READ, 0, 0, 0, 0));
        settle();
        write_reg(REG_MAX_ENTRIES, 7'd0);
        write_reg(REG_LIST_ENABLED, 7'd1);
        queue_item(mk(KIND_APPEND, 0, 1, 1, 1));
        queue_item(mk(KIND_INSERT, 0, 1, 1, 1));

        sent = 0;
        while (sent < ITEM_GOAL) begin
            settle();
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            if (sent > ITEM_GOAL - 150) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                write_reg(REG_LIST_ENABLED, {6'($urandom), 1'b0});
                write_reg(REG_MAX_ENTRIES, pick_capacity());
                if (mode == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 7'($urandom));
                write_reg(REG_LIST_ENABLED, {6'($urandom), 1'b1});
            end else if (mode < 8) begin
                write_reg(REG_LIST_ENABLED, {6'($urandom), 1'b1});
                write_reg(REG_MAX_ENTRIES, pick_capacity());
            end else if (mode == 8) begin
                write_reg(REG_LIST_ENABLED, {6'($urandom), 1'b0});
            end
            n = list_on ? $urandom_range(40, 140) : $urandom_range(5, 15);
            repeat (n) queue_item(rand_request());
        end

        settle();
        repeat (5) @(posedge i_clk);
        if (owed_results.size() != 0)
            report_mismatch("results never seen", 0, owed_results.size());
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
